>>> sv/cbes_pkg.sv
// cubic bezier easing solver: shared types and constants
// no dependencies; imported by cbes_fxmul and the top level
package cbes_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHECK
    } t_state;

    // one product per cycle through the shared multiplier
    typedef enum logic [2:0] {
        OP_TT,
        OP_TU,
        OP_B1,
        OP_B2,
        OP_B3,
        OP_P1,
        OP_P2
    } t_op;

    localparam logic       CFG_TOLERANCE = 1'b0;
    localparam logic       CFG_MAX_ITER  = 1'b1;
    localparam logic [15:0] TOL_RESET     = 16'd168;
    localparam logic [6:0]  MAX_ITER_RESET = 7'd100;
    localparam logic [16:0] EASED_MAX     = 17'd32768;

endpackage

>>> sv/cbes_fxmul.sv
// cubic bezier easing solver: shared fixed point multiplier
// product of two unsigned inner values, floored back to FRAC fraction bits
// uses cbes_pkg
module cbes_fxmul
    import cbes_pkg::*;
#(
    parameter int FRAC  = 24,
    parameter int WIDTH = 26
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_p
);

    logic [2*WIDTH-1:0] w_full;

    assign w_full = {{WIDTH{1'b0}}, i_a} * {{WIDTH{1'b0}}, i_b};
    // operands stay below 4.0 and products below 4.0, so the top bits are zero
    assign o_p    = w_full[FRAC +: WIDTH];

endmodule

>>> sv/cubic_bezier_easing_solver.sv
// Channel   Direction  Handshake               Word
// input     in         i_in_valid / o_in_stall  progress, ctrl1_x/y, ctrl2_x/y (Q1.15)
// output    out        o_out_valid / i_out_stall eased, param_found, steps_used
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One x evaluation is 7 products through the single shared multiplier, one
// sum and one compare; each bisection step repeats it. The y pass then reuses
// the final bases for the two control point products, a sum and a compare.
// The input is stalled from acceptance until the result is loaded into the
// output register; the next word is taken while that result waits.
// Reset is synchronous, active low, and restores both config registers.
module cubic_bezier_easing_solver
    import cbes_pkg::*;
#(
    parameter int INNER_FRAC_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_progress,
    input  logic [15:0] i_ctrl1_x,
    input  logic [15:0] i_ctrl1_y,
    input  logic [15:0] i_ctrl2_x,
    input  logic [15:0] i_ctrl2_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_eased,
    output logic [15:0] o_param_found,
    output logic [6:0]  o_steps_used,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int F      = INNER_FRAC_BITS;
    localparam int TW     = F + 1;
    localparam int W      = F + 2;
    localparam int TolShl = (F >= 24) ? F - 24 : 0;
    localparam int TolShr = (F >= 24) ? 0 : 24 - F;
    localparam logic [TW-1:0] One  = {1'b1, {F{1'b0}}};
    localparam logic [TW-1:0] Half = One >> 1;
    localparam logic [W-1:0]  RndW = W'(1) << (F - 16);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_ypass, n_ypass;

    logic [15:0] r_tol;
    logic [6:0]  r_max_iter;

    logic [15:0] r_target, r_c1x, r_c1y, r_c2x, r_c2y;
    logic [TW-1:0] r_lo, n_lo, r_hi, n_hi, r_t, n_t, r_u, n_u;
    logic [W-1:0] r_tt, n_tt, r_tu, n_tu, r_b1, n_b1, r_b2, n_b2, r_b3, n_b3;
    logic [W-1:0] r_p1, n_p1, r_p2, n_p2, r_sum, n_sum;
    logic [6:0]  r_steps, n_steps;

    logic        r_out_valid, n_out_valid;
    logic [15:0] r_eased, n_eased, r_param, n_param;
    logic [6:0]  r_steps_out, n_steps_out;

    logic [W-1:0] w_mul_a, w_mul_b, w_prod, w_prod3;
    logic [W-1:0] w_target, w_tol, w_err;
    logic         w_done, w_out_free, w_load_out, w_accept;
    logic [TW-1:0] w_lo, w_hi;
    logic [TW:0]   w_mid;
    logic [W-1:0]  w_y_rnd;
    logic [16:0]   w_y_q;
    logic [TW-1:0] w_t_rnd;

    function automatic logic [W-1:0] widen(input logic [15:0] q15);
        return W'({q15, {(F - 15){1'b0}}});
    endfunction

    cbes_fxmul #(
        .FRAC  (F),
        .WIDTH (W)
    ) u_mul (
        .i_a (w_mul_a),
        .i_b (w_mul_b),
        .o_p (w_prod)
    );

    assign w_prod3 = w_prod + (w_prod << 1);

    always_comb begin
        case (r_op)
            OP_TT: begin
                w_mul_a = W'(r_t);
                w_mul_b = W'(r_t);
            end
            OP_TU: begin
                w_mul_a = W'(r_t);
                w_mul_b = W'(r_u);
            end
            OP_B1: begin
                w_mul_a = r_tu;
                w_mul_b = W'(r_u);
            end
            OP_B2: begin
                w_mul_a = r_tt;
                w_mul_b = W'(r_u);
            end
            OP_B3: begin
                w_mul_a = r_tt;
                w_mul_b = W'(r_t);
            end
            OP_P1: begin
                w_mul_a = widen(r_ypass ? r_c1y : r_c1x);
                w_mul_b = r_b1;
            end
            OP_P2: begin
                w_mul_a = widen(r_ypass ? r_c2y : r_c2x);
                w_mul_b = r_b2;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // search decision on the registered curve x
    assign w_target = widen(r_target);
    assign w_tol    = (W'(r_tol) << TolShl) >> TolShr;
    assign w_err    = (w_target > r_sum) ? w_target - r_sum : r_sum - w_target;
    assign w_done   = (w_err <= w_tol) || (r_steps >= r_max_iter);
    assign w_lo     = (w_target < r_sum) ? r_lo : r_t;
    assign w_hi     = (w_target < r_sum) ? r_t : r_hi;
    assign w_mid    = {1'b0, w_lo} + {1'b0, w_hi};

    // rounding to Q1.15
    assign w_y_rnd = r_sum + RndW;
    assign w_y_q   = w_y_rnd[W-1 -: 17];
    assign w_t_rnd = r_t + RndW[TW-1:0];

    assign w_accept   = (r_state == ST_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (r_state == ST_CHECK) && r_ypass && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_op == OP_P2) n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_ypass) begin
                    if (w_out_free) n_state = ST_IDLE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath next values
    always_comb begin
        n_op        = r_op;
        n_ypass     = r_ypass;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_t         = r_t;
        n_u         = r_u;
        n_tt        = r_tt;
        n_tu        = r_tu;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_b3        = r_b3;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_sum       = r_sum;
        n_steps     = r_steps;
        n_eased     = r_eased;
        n_param     = r_param;
        n_steps_out = r_steps_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                n_op    = OP_TT;
                n_ypass = 1'b0;
                n_lo    = '0;
                n_hi    = One;
                n_t     = Half;
                n_steps = '0;
            end
            ST_MUL: begin
                case (r_op)
                    OP_TT: begin
                        n_tt = w_prod;
                        n_u  = One - r_t;
                        n_op = OP_TU;
                    end
                    OP_TU: begin
                        n_tu = w_prod;
                        n_op = OP_B1;
                    end
                    OP_B1: begin
                        n_b1 = w_prod3;
                        n_op = OP_B2;
                    end
                    OP_B2: begin
                        n_b2 = w_prod3;
                        n_op = OP_B3;
                    end
                    OP_B3: begin
                        n_b3 = w_prod;
                        n_op = OP_P1;
                    end
                    OP_P1: begin
                        n_p1 = w_prod;
                        n_op = OP_P2;
                    end
                    OP_P2: begin
                        n_p2 = w_prod;
                    end
                    default: begin
                        n_op = OP_TT;
                    end
                endcase
            end
            ST_SUM: begin
                n_sum = r_p1 + r_p2 + r_b3;
            end
            ST_CHECK: begin
                if (r_ypass) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_eased     = (w_y_q > EASED_MAX) ? EASED_MAX[15:0] : w_y_q[15:0];
                        n_param     = w_t_rnd[F -: 16];
                        n_steps_out = r_steps;
                    end
                end else if (w_done) begin
                    // bases at the final t are kept; only the y products remain
                    n_ypass = 1'b1;
                    n_op    = OP_P1;
                end else begin
                    n_lo    = w_lo;
                    n_hi    = w_hi;
                    n_t     = w_mid[TW:1];
                    n_steps = r_steps + 7'd1;
                    n_op    = OP_TT;
                end
            end
            default: begin
                n_op = OP_TT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
            r_max_iter  <= MAX_ITER_RESET;
            r_op        <= OP_TT;
            r_ypass     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            r_ypass     <= n_ypass;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOLERANCE: r_tol      <= i_cfg_data;
                    CFG_MAX_ITER:  r_max_iter <= i_cfg_data[6:0];
                    default:       r_tol      <= r_tol;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_target <= i_progress;
            r_c1x    <= i_ctrl1_x;
            r_c1y    <= i_ctrl1_y;
            r_c2x    <= i_ctrl2_x;
            r_c2y    <= i_ctrl2_y;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_t         <= n_t;
        r_u         <= n_u;
        r_tt        <= n_tt;
        r_tu        <= n_tu;
        r_b1        <= n_b1;
        r_b2        <= n_b2;
        r_b3        <= n_b3;
        r_p1        <= n_p1;
        r_p2        <= n_p2;
        r_sum       <= n_sum;
        r_steps     <= n_steps;
        r_eased     <= n_eased;
        r_param     <= n_param;
        r_steps_out <= n_steps_out;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_eased       = r_eased;
    assign o_param_found = r_param;
    assign o_steps_used  = r_steps_out;
    // registers only change between items
    assign o_cfg_ready   = (r_state == ST_IDLE);

`ifndef NO_ASSERTIONS
    // t always stays inside the bracket while a search runs
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_lo <= r_t) && (r_t <= r_hi))
        else $error("bisection bracket broken");

    // a new result only appears from the final compare of the y pass
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_CHECK && $past(r_ypass))
        else $error("result loaded outside y pass");

    // results are saturated and rounded into range
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_eased <= 16'd32768) && (o_param_found <= 16'd32768))
        else $error("result out of range");

    // a y pass only starts once the search has stopped
    a_ypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ypass) |-> $past(r_state) == ST_CHECK && $past(w_done))
        else $error("y pass entered early");
`endif

endmodule

>>> verif/cubic_bezier_easing_solver_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for cubic_bezier_easing_solver: directed table, then random phases
// results not typed in come from a bisection solver here; depends on cbes_pkg and the rtl
module cubic_bezier_easing_solver_tb;
    import cbes_pkg::*;

    localparam int          FRAC         = 24;
    localparam logic [63:0] ONE_Q        = 64'd1 << FRAC;
    localparam int          TAIL_CYCLES  = 50;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [15:0] progress;
        logic [15:0] ctrl1_x;
        logic [15:0] ctrl1_y;
        logic [15:0] ctrl2_x;
        logic [15:0] ctrl2_y;
    } t_word;

    typedef struct packed {
        logic [15:0] eased;
        logic [15:0] param_found;
        logic [6:0]  steps_used;
    } t_result;

    typedef struct packed {
        t_word       w;
        logic [15:0] tol;
        logic [6:0]  maxit;
        logic        typed;
        t_result     want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [15:0] i_progress    = '0;
    logic [15:0] i_ctrl1_x     = '0;
    logic [15:0] i_ctrl1_y     = '0;
    logic [15:0] i_ctrl2_x     = '0;
    logic [15:0] i_ctrl2_y     = '0;
    logic        i_out_stall   = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        i_cfg_index   = CFG_TOLERANCE;
    logic [15:0] i_cfg_data    = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_eased;
    logic [15:0] o_param_found;
    logic [6:0]  o_steps_used;
    logic        o_cfg_ready;

    // register copies seen by the solver below
    logic [15:0] cfg_tol   = TOL_RESET;
    logic [6:0]  cfg_maxit = MAX_ITER_RESET;

    t_result     pending_results[$];
    t_row        directed_rows[$];
    t_result     due;
    int          n_fail         = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    cubic_bezier_easing_solver #(
        .INNER_FRAC_BITS(FRAC)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_progress   (i_progress),
        .i_ctrl1_x    (i_ctrl1_x),
        .i_ctrl1_y    (i_ctrl1_y),
        .i_ctrl2_x    (i_ctrl2_x),
        .i_ctrl2_y    (i_ctrl2_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_eased      (o_eased),
        .o_param_found(o_param_found),
        .o_steps_used (o_steps_used),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- fixed-point solver ----------------

    // full product, floored back to FRAC fraction bits
    function automatic logic [63:0] fx_mul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FRAC +: 64];
    endfunction

    function automatic logic [63:0] widen_q(input logic [15:0] q);
        return {48'd0, q} << (FRAC - 15);
    endfunction

    function automatic logic [63:0] narrow_q(input logic [63:0] v);
        return (v + (64'd1 << (FRAC - 16))) >> (FRAC - 15);
    endfunction

    function automatic void bernstein(input logic [63:0] t, output logic [63:0] b1,
                                      output logic [63:0] b2, output logic [63:0] b3);
        logic [63:0] u;
        logic [63:0] tt;
        u  = ONE_Q - t;
        tt = fx_mul_q(t, t);
        b1 = 64'd3 * fx_mul_q(fx_mul_q(t, u), u);
        b2 = 64'd3 * fx_mul_q(tt, u);
        b3 = fx_mul_q(tt, t);
    endfunction

    // one coordinate of the curve; end points fixed at 0 and 1
    function automatic logic [63:0] bezier_at(input logic [63:0] t, input logic [63:0] c1,
                                              input logic [63:0] c2);
        logic [63:0] b1, b2, b3;
        bernstein(t, b1, b2, b3);
        return fx_mul_q(c1, b1) + fx_mul_q(c2, b2) + b3;
    endfunction

    function automatic t_result solve_easing(input t_word w, input logic [15:0] tol,
                                             input logic [6:0] maxit);
        logic [63:0] target, c1x, c1y, c2x, c2y, tol_q;
        logic [63:0] lo, hi, t, x, err, y, e, tr;
        int          steps;
        t_result     r;
        target = widen_q(w.progress);
        c1x    = widen_q(w.ctrl1_x);
        c1y    = widen_q(w.ctrl1_y);
        c2x    = widen_q(w.ctrl2_x);
        c2y    = widen_q(w.ctrl2_y);
        // tolerance is given in Q1.24 units
        tol_q  = {48'd0, tol} << (FRAC - 24);
        lo     = '0;
        hi     = ONE_Q;
        t      = ONE_Q >> 1;
        x      = bezier_at(t, c1x, c2x);
        steps  = 0;
        err    = (target > x) ? target - x : x - target;
        while (err > tol_q && steps < int'(maxit)) begin
            if (target < x)
                hi = t;
            else
                lo = t;
            t     = (lo + hi) >> 1;
            x     = bezier_at(t, c1x, c2x);
            steps = steps + 1;
            err   = (target > x) ? target - x : x - target;
        end
        y = bezier_at(t, c1y, c2y);
        e = narrow_q(y);
        if (e > {47'd0, EASED_MAX})
            e = {47'd0, EASED_MAX};
        tr = narrow_q(t);
        r.eased       = e[15:0];
        r.param_found = tr[15:0];
        r.steps_used  = steps[6:0];
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic [15:0] rand_field();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 16'($urandom_range(32768, 0));
        if (pick < 80)
            return pick[0] ? 16'd32768 : 16'd0;
        return 16'($urandom);
    endfunction

    // drop valid and let every outstanding result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    task automatic send_word(input t_word w, input logic typed, input t_result want);
        t_result exp_r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_progress <= w.progress;
        i_ctrl1_x  <= w.ctrl1_x;
        i_ctrl1_y  <= w.ctrl1_y;
        i_ctrl2_x  <= w.ctrl2_x;
        i_ctrl2_y  <= w.ctrl2_y;
        @(negedge i_clk);
        while (o_in_stall)
            @(negedge i_clk);
        // word is taken at the coming edge
        exp_r = typed ? want : solve_easing(w, cfg_tol, cfg_maxit);
        pending_results = {pending_results, exp_r};
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] tol, input logic [6:0] maxit);
        logic [8:0] pad;
        pad = 9'($urandom);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TOLERANCE;
        i_cfg_data  <= tol;
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        cfg_tol = tol;
        @(posedge i_clk);
        // upper bits of the step limit word are don't-care
        i_cfg_index <= CFG_MAX_ITER;
        i_cfg_data  <= {pad, maxit};
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        cfg_maxit = maxit;
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [15:0] p, input logic [15:0] c1x, input logic [15:0] c1y,
                           input logic [15:0] c2x, input logic [15:0] c2y,
                           input logic [15:0] tol, input logic [6:0] maxit, input logic typed,
                           input logic [15:0] e, input logic [15:0] pf, input logic [6:0] s);
        t_row r;
        r.w     = {p, c1x, c1y, c2x, c2y};
        r.tol   = tol;
        r.maxit = maxit;
        r.typed = typed;
        r.want  = {e, pf, s};
        directed_rows = {directed_rows, r};
    endtask

    task automatic run_phase(input logic [15:0] tol, input logic [6:0] maxit,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int n);
        t_word w;
        set_config(tol, maxit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < n; k++) begin
            // hold off half way until the block is empty
            if (k == n / 2)
                wait_drained();
            w.progress = rand_field();
            w.ctrl1_x  = rand_field();
            w.ctrl1_y  = rand_field();
            w.ctrl2_x  = rand_field();
            w.ctrl2_y  = rand_field();
            send_word(w, 1'b0, '0);
        end
    endtask

    // ---------------- receiver and checker ----------------

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: eased %0d param_found %0d steps_used %0d",
                       o_eased, o_param_found, o_steps_used);
                n_fail++;
            end else begin
                due = pending_results.pop_front();
                if (o_eased !== due.eased) begin
                    $error("eased: expected %0d, got %0d", due.eased, o_eased);
                    n_fail++;
                end
                if (o_param_found !== due.param_found) begin
                    $error("param_found: expected %0d, got %0d", due.param_found,
                           o_param_found);
                    n_fail++;
                end
                if (o_steps_used !== due.steps_used) begin
                    $error("steps_used: expected %0d, got %0d", due.steps_used, o_steps_used);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ---------------- sequence ----------------

    initial begin
        t_row r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: symmetric curve hits the target at t = 0.5
        add_row(16384, 16384, 16384, 16384, 16384, TOL_RESET, MAX_ITER_RESET, 1'b1,
                16384, 16384, 0);
        add_row(0, 0, 0, 0, 0, TOL_RESET, MAX_ITER_RESET, 1'b0, 0, 0, 0);
        add_row(32768, 32768, 32768, 32768, 32768, TOL_RESET, MAX_ITER_RESET, 1'b0, 0, 0, 0);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, TOL_RESET, MAX_ITER_RESET,
                1'b0, 0, 0, 0);
        // target out of the curve's reach, then control points at the top of their range
        add_row(16'hFFFF, 0, 0, 0, 0, TOL_RESET, MAX_ITER_RESET, 1'b0, 0, 0, 0);
        add_row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, TOL_RESET, MAX_ITER_RESET,
                1'b0, 0, 0, 0);
        // no steps allowed: y read at t = 0.5
        add_row(0, 0, 0, 0, 0, TOL_RESET, 0, 1'b1, 4096, 16384, 0);
        add_row(12345, 32768, 32768, 32768, 32768, TOL_RESET, 0, 1'b1, 28672, 16384, 0);
        // y above 1.0 saturates
        add_row(0, 0, 16'hFFFF, 0, 16'hFFFF, TOL_RESET, 0, 1'b1, 32768, 16384, 0);
        // zero and full tolerance, normal and largest step limit, then one step and patterns
        add_row(16'h5555, 16'h1111, 16'h2222, 16'h7777, 16'h6666, 0, 100, 1'b0, 0, 0, 0);
        add_row(16'h2AAA, 16'h7FFF, 16'h0001, 16'h0000, 16'h8000, 0, 127, 1'b0, 0, 0, 0);
        add_row(16'h7FFF, 16'h4000, 16'h1000, 16'h2000, 16'h7000, 16'hFFFF, 100,
                1'b0, 0, 0, 0);
        add_row(32768, 0, 32768, 32768, 0, 16'hFFFF, 127, 1'b0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, TOL_RESET, 1, 1'b0, 0, 0, 0);
        add_row(1, 1, 1, 1, 1, TOL_RESET, MAX_ITER_RESET, 1'b0, 0, 0, 0);
        add_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, TOL_RESET, MAX_ITER_RESET,
                1'b0, 0, 0, 0);
        add_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, TOL_RESET, MAX_ITER_RESET,
                1'b0, 0, 0, 0);

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            if (r.tol != cfg_tol || r.maxit != cfg_maxit)
                set_config(r.tol, r.maxit);
            send_word(r.w, r.typed, r.want);
        end

        run_phase(TOL_RESET, MAX_ITER_RESET, 0, 0, 80);
        run_phase(TOL_RESET, MAX_ITER_RESET, 73, 0, 60);
        run_phase(16'($urandom_range(2000, 0)), 7'($urandom_range(40, 10)), 0, 73, 60);
        run_phase(0, 30, 24, 24, 50);
        run_phase(16'hFFFF, 100, 0, 0, 50);
        run_phase(300, 127, 73, 0, 20);
        run_phase(0, 127, 0, 73, 10);
        run_phase(16'($urandom), 7'($urandom_range(20, 0)), 24, 24, 60);
        run_phase(TOL_RESET, MAX_ITER_RESET, 0, 0, 50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
